// ===== rtl/erot_pkg.sv =====
package erot_pkg;

  // block configuration
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int COORD_WIDTH      = 32;
  localparam int ANGLE_BITS       = 16;

  // configuration port
  localparam int CFG_DATA_W  = ANGLE_BITS;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_YAW,
    REG_PITCH,
    REG_ROLL
  } reg_idx_t;

  // coefficient format, signed Q1.16
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 16;
  localparam int SINE_W    = 17;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [8:0] coef_vec_t;

  typedef struct packed {
    logic      ready;
    coef_vec_t coef;
  } coef_status_t;

  // vertex format
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  localparam int VPROD_W = COEF_W + COORD_WIDTH;
  localparam int VSUM_W  = VPROD_W + 2;

  // sine lookup
  localparam int ROM_IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QUARTER_SH = ANGLE_BITS - 2;
  localparam int QUARTER    = 1 << QUARTER_SH;
  localparam int RQ_W       = QUARTER_SH + 1;
  localparam int IDX_PROD_W = RQ_W + ROM_IDX_W;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  // quarter-wave table, taylor series through x^15 in Q30, rounded to Q16
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64'sd8192) >>> 14;
      if (v > 64'sd65536) begin
        v = 64'sd65536;
      end
      rom[i] = SINE_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // coefficient builder sequencer
  localparam int LOOKUP_COUNT = 6;
  localparam int MAC_STEPS    = 16;
  localparam int STEP_W       = $clog2(MAC_STEPS);
  localparam int MAC_ACC_W    = 2 * COEF_W + 1;

  localparam coef_t COEF_ONE = COEF_W'(1 << COEF_FRAC);

  typedef enum logic [1:0] {
    BLD_LOOKUP,
    BLD_DRAIN,
    BLD_MATRIX,
    BLD_DONE
  } bld_state_t;

  // operand sources; the first six follow the lookup order
  typedef enum logic [3:0] {
    SRC_SY,
    SRC_CY,
    SRC_SP,
    SRC_CP,
    SRC_SR,
    SRC_CR,
    SRC_CYSP,
    SRC_SYSP,
    SRC_ONE
  } src_t;

  typedef enum logic [2:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB,
    MAC_NEG,
    MAC_HOLD
  } mac_mode_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_COEF,
    DST_CYSP,
    DST_SYSP
  } dst_t;

  typedef struct packed {
    src_t        a;
    src_t        b;
    mac_mode_t   mode;
    dst_t        dst;
    logic [3:0]  idx;
  } uop_t;

endpackage

// ===== rtl/erot_coef_build.sv =====
module erot_coef_build (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [erot_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [erot_pkg::CFG_DATA_W-1:0]  cfg_data,
  output erot_pkg::coef_status_t           status
);
  import erot_pkg::*;

  localparam logic signed [MAC_ACC_W-1:0] CLAMP_HI = MAC_ACC_W'((1 << (COEF_W - 1)) - 1);
  localparam logic signed [MAC_ACC_W-1:0] CLAMP_LO = -CLAMP_HI - 1;

  logic [ANGLE_BITS-1:0] yaw;
  logic [ANGLE_BITS-1:0] pitch;
  logic [ANGLE_BITS-1:0] roll;

  bld_state_t        state;
  bld_state_t        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  logic restart;
  logic issue_en;
  logic mac_en;
  logic ready;

  // lookup path
  logic [ANGLE_BITS-1:0] angle_sel;
  logic [ANGLE_BITS-1:0] angle;
  logic [1:0]            quad;
  logic [RQ_W-1:0]       rq;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [ROM_IDX_W-1:0]  rom_addr;
  logic [SINE_W-1:0]     rom_q;
  logic                  neg_q;
  src_t                  dest_q;
  logic                  look_vld;
  coef_t                 trig_val;

  coef_t sy, cy, sp, cp, sr, cr;
  coef_t cysp, sysp;

  // matrix path
  uop_t                        uop;
  coef_t                       op_a;
  coef_t                       op_b;
  logic signed [2*COEF_W-1:0]  prod;
  logic signed [MAC_ACC_W-1:0] acc;
  logic signed [MAC_ACC_W-1:0] acc_next;
  logic signed [MAC_ACC_W-1:0] acc_rnd;
  logic signed [MAC_ACC_W-1:0] acc_clamp;
  coef_t                       wb_val;
  coef_vec_t                   coefs;

  function automatic uop_t mac_program(input logic [STEP_W-1:0] s);
    uop_t u;
    u.a    = SRC_ONE;
    u.b    = SRC_ONE;
    u.mode = MAC_HOLD;
    u.dst  = DST_NONE;
    u.idx  = '0;
    unique case (s)
      0:  begin u.a = SRC_CY;   u.b = SRC_CP;  u.mode = MAC_LOAD; end
      1:  begin u.a = SRC_CY;   u.b = SRC_SP;  u.mode = MAC_LOAD;
                u.dst = DST_COEF; u.idx = 4'd0; end
      2:  begin u.a = SRC_SY;   u.b = SRC_SP;  u.mode = MAC_LOAD;
                u.dst = DST_CYSP; end
      3:  begin u.a = SRC_SY;   u.b = SRC_CP;  u.mode = MAC_LOAD;
                u.dst = DST_SYSP; end
      4:  begin u.a = SRC_CP;   u.b = SRC_SR;  u.mode = MAC_LOAD;
                u.dst = DST_COEF; u.idx = 4'd3; end
      5:  begin u.a = SRC_CP;   u.b = SRC_CR;  u.mode = MAC_LOAD;
                u.dst = DST_COEF; u.idx = 4'd7; end
      6:  begin u.a = SRC_CYSP; u.b = SRC_SR;  u.mode = MAC_LOAD;
                u.dst = DST_COEF; u.idx = 4'd8; end
      7:  begin u.a = SRC_SY;   u.b = SRC_CR;  u.mode = MAC_SUB; end
      8:  begin u.a = SRC_CYSP; u.b = SRC_CR;  u.mode = MAC_LOAD;
                u.dst = DST_COEF; u.idx = 4'd1; end
      9:  begin u.a = SRC_SY;   u.b = SRC_SR;  u.mode = MAC_ADD; end
      10: begin u.a = SRC_SYSP; u.b = SRC_SR;  u.mode = MAC_LOAD;
                u.dst = DST_COEF; u.idx = 4'd2; end
      11: begin u.a = SRC_CY;   u.b = SRC_CR;  u.mode = MAC_ADD; end
      12: begin u.a = SRC_SYSP; u.b = SRC_CR;  u.mode = MAC_LOAD;
                u.dst = DST_COEF; u.idx = 4'd4; end
      13: begin u.a = SRC_CY;   u.b = SRC_SR;  u.mode = MAC_SUB; end
      14: begin u.a = SRC_SP;   u.b = SRC_ONE; u.mode = MAC_NEG;
                u.dst = DST_COEF; u.idx = 4'd5; end
      default: begin u.dst = DST_COEF; u.idx = 4'd6; end
    endcase
    return u;
  endfunction

  // config decode: a valid register write restarts the build
  always_comb begin
    restart = 1'b0;
    if (cfg_write_en) begin
      unique case (cfg_index)
        REG_YAW, REG_PITCH, REG_ROLL: restart = 1'b1;
        default:                      restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw   <= '0;
      pitch <= '0;
      roll  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_YAW:   yaw   <= ANGLE_BITS'(cfg_data);
        REG_PITCH: pitch <= ANGLE_BITS'(cfg_data);
        REG_ROLL:  roll  <= ANGLE_BITS'(cfg_data);
        default:   ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      BLD_LOOKUP: begin
        if (step == STEP_W'(LOOKUP_COUNT - 1)) begin
          state_next = BLD_DRAIN;
          step_next  = '0;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      BLD_DRAIN: begin
        state_next = BLD_MATRIX;
        step_next  = '0;
      end
      BLD_MATRIX: begin
        if (step == STEP_W'(MAC_STEPS - 1)) begin
          state_next = BLD_DONE;
          step_next  = '0;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      BLD_DONE: ;
    endcase
    if (restart) begin
      state_next = BLD_LOOKUP;
      step_next  = '0;
    end
  end

  always_comb begin
    issue_en = 1'b0;
    mac_en   = 1'b0;
    ready    = 1'b0;
    unique case (state)
      BLD_LOOKUP: issue_en = 1'b1;
      BLD_DRAIN:  ;
      BLD_MATRIX: mac_en   = 1'b1;
      BLD_DONE:   ready    = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BLD_LOOKUP;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // lookup address: even steps sine, odd steps cosine
  always_comb begin
    unique case (step[2:1])
      2'd0:    angle_sel = yaw;
      2'd1:    angle_sel = pitch;
      default: angle_sel = roll;
    endcase
    angle    = angle_sel + (step[0] ? ANGLE_BITS'(QUARTER) : '0);
    quad     = angle[ANGLE_BITS-1 -: 2];
    rq       = quad[0] ? RQ_W'(QUARTER) - RQ_W'(angle[QUARTER_SH-1:0])
                       : RQ_W'(angle[QUARTER_SH-1:0]);
    idx_prod = IDX_PROD_W'(rq) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    rom_addr = ROM_IDX_W'(idx_prod >> QUARTER_SH);
  end

  always_ff @(posedge clk) begin
    rom_q  <= SINE_ROM[rom_addr];
    neg_q  <= quad[1];
    dest_q <= src_t'({1'b0, step[2:0]});
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      look_vld <= 1'b0;
    end else begin
      look_vld <= issue_en;
    end
  end

  assign trig_val = neg_q ? -signed'(COEF_W'(rom_q)) : signed'(COEF_W'(rom_q));

  always_ff @(posedge clk) begin
    if (look_vld) begin
      unique case (dest_q)
        SRC_SY:  sy <= trig_val;
        SRC_CY:  cy <= trig_val;
        SRC_SP:  sp <= trig_val;
        SRC_CP:  cp <= trig_val;
        SRC_SR:  sr <= trig_val;
        SRC_CR:  cr <= trig_val;
        default: ;
      endcase
    end
  end

  // shared multiply-accumulate
  assign uop = mac_program(step);

  always_comb begin
    unique case (uop.a)
      SRC_SY:   op_a = sy;
      SRC_CY:   op_a = cy;
      SRC_SP:   op_a = sp;
      SRC_CP:   op_a = cp;
      SRC_SR:   op_a = sr;
      SRC_CR:   op_a = cr;
      SRC_CYSP: op_a = cysp;
      SRC_SYSP: op_a = sysp;
      default:  op_a = COEF_ONE;
    endcase
    unique case (uop.b)
      SRC_SY:   op_b = sy;
      SRC_CY:   op_b = cy;
      SRC_SP:   op_b = sp;
      SRC_CP:   op_b = cp;
      SRC_SR:   op_b = sr;
      SRC_CR:   op_b = cr;
      SRC_CYSP: op_b = cysp;
      SRC_SYSP: op_b = sysp;
      default:  op_b = COEF_ONE;
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    unique case (uop.mode)
      MAC_LOAD: acc_next = MAC_ACC_W'(prod);
      MAC_ADD:  acc_next = acc + MAC_ACC_W'(prod);
      MAC_SUB:  acc_next = acc - MAC_ACC_W'(prod);
      MAC_NEG:  acc_next = -MAC_ACC_W'(prod);
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mac_en) begin
      acc <= acc_next;
    end
  end

  // write back the previous step's sum, rounded and clamped to Q1.16
  always_comb begin
    acc_rnd = (acc + signed'(MAC_ACC_W'(1 << (COEF_FRAC - 1)))) >>> COEF_FRAC;
    if (acc_rnd > CLAMP_HI) begin
      acc_clamp = CLAMP_HI;
    end else if (acc_rnd < CLAMP_LO) begin
      acc_clamp = CLAMP_LO;
    end else begin
      acc_clamp = acc_rnd;
    end
    wb_val = COEF_W'(acc_clamp);
  end

  always_ff @(posedge clk) begin
    if (mac_en) begin
      unique case (uop.dst)
        DST_COEF: coefs[uop.idx] <= wb_val;
        DST_CYSP: cysp <= wb_val;
        DST_SYSP: sysp <= wb_val;
        DST_NONE: ;
      endcase
    end
  end

  assign status.ready = ready;
  assign status.coef  = coefs;

endmodule

// ===== rtl/erot_vertex_pipe.sv =====
module erot_vertex_pipe (
  input  logic                   clk,
  input  logic                   rst,
  input  erot_pkg::coef_status_t coef_status,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  erot_pkg::vec3_t        in_vec,
  output logic                   out_valid,
  input  logic                   out_stall,
  output erot_pkg::vec3_t        out_vec
);
  import erot_pkg::*;

  localparam logic signed [VSUM_W-1:0] OUT_HI =
    signed'(VSUM_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1));
  localparam logic signed [VSUM_W-1:0] OUT_LO = -OUT_HI - 1;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  vec3_t                     x1;
  logic signed [VPROD_W-1:0] prod2 [9];
  logic signed [VSUM_W-1:0]  sum3  [3];
  logic signed [VSUM_W-1:0]  rnd3  [3];
  vec3_t                     sat3;
  vec3_t                     out4;

  // a stage takes new data when it is empty or its successor moves
  assign rdy4 = !v4 || !out_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign in_stall = !(rdy1 && coef_status.ready);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= accept;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1 <= in_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod2[j*3+k] <= signed'(coef_status.coef[j*3+k]) * signed'(x1[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int j = 0; j < 3; j++) begin
        sum3[j] <= VSUM_W'(prod2[j*3]) + VSUM_W'(prod2[j*3+1]) + VSUM_W'(prod2[j*3+2]);
      end
    end
  end

  // round off the 16 fraction bits of the coefficients, then saturate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rnd3[j] = (sum3[j] + signed'(VSUM_W'(1 << (COEF_FRAC - 1)))) >>> COEF_FRAC;
      if (rnd3[j] > OUT_HI) begin
        sat3[j] = COORD_WIDTH'(OUT_HI);
      end else if (rnd3[j] < OUT_LO) begin
        sat3[j] = COORD_WIDTH'(OUT_LO);
      end else begin
        sat3[j] = COORD_WIDTH'(rnd3[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out4 <= sat3;
    end
  end

  assign out_valid = v4;
  assign out_vec   = out4;

endmodule

// ===== rtl/euler_angle_vector_rotator.sv =====
// channel   | handshake                     | payload
// ----------+-------------------------------+---------------------------------
// vertex    | vertex_valid / vertex_stall   | vertex_x, vertex_y, vertex_z
// rotated   | rotated_valid / rotated_stall | rotated_x, rotated_y, rotated_z
// config    | cfg_write_en (no wait)        | cfg_index, cfg_data
//
// one vertex per cycle while the matrix is ready and rotated_stall is low; stages
// are input register, nine 18x32 multipliers, row adders, round and saturate
// after reset and after each angle write the coefficient builder runs six table
// lookups, one drain and sixteen steps of its one multiplier; vertex_stall
// stays high until it is done
// rst is synchronous and active high; it clears valid bits, angles and the
// builder sequencer
// rotated_stall holds the output register; stages in front keep filling
// their empty slots, so vertices are taken while a result waits
module euler_angle_vector_rotator (
  input  logic                             clk,
  input  logic                             rst,

  // config write port
  input  logic                             cfg_write_en,
  input  logic [erot_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [erot_pkg::CFG_DATA_W-1:0]  cfg_data,

  // vertex in
  input  logic                             vertex_valid,
  output logic                             vertex_stall,
  input  logic signed [erot_pkg::COORD_WIDTH-1:0] vertex_x,
  input  logic signed [erot_pkg::COORD_WIDTH-1:0] vertex_y,
  input  logic signed [erot_pkg::COORD_WIDTH-1:0] vertex_z,

  // rotated vertex out
  output logic                             rotated_valid,
  input  logic                             rotated_stall,
  output logic signed [erot_pkg::COORD_WIDTH-1:0] rotated_x,
  output logic signed [erot_pkg::COORD_WIDTH-1:0] rotated_y,
  output logic signed [erot_pkg::COORD_WIDTH-1:0] rotated_z
);
  import erot_pkg::*;

  coef_status_t coef_status;
  vec3_t        in_vec;
  vec3_t        out_vec;

  // angle registers, sine table and the sequenced matrix build
  erot_coef_build u_coef_build (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (coef_status)
  );

  // lane 0 is x, lane 1 is y, lane 2 is z
  assign in_vec[0] = vertex_x;
  assign in_vec[1] = vertex_y;
  assign in_vec[2] = vertex_z;

  // matrix times vertex, four register stages
  erot_vertex_pipe u_vertex_pipe (
    .clk         (clk),
    .rst         (rst),
    .coef_status (coef_status),
    .in_valid    (vertex_valid),
    .in_stall    (vertex_stall),
    .in_vec      (in_vec),
    .out_valid   (rotated_valid),
    .out_stall   (rotated_stall),
    .out_vec     (out_vec)
  );

  assign rotated_x = out_vec[0];
  assign rotated_y = out_vec[1];
  assign rotated_z = out_vec[2];

  // a vertex transfer only happens with a finished matrix
  a_transfer_needs_coef: assert property (@(posedge clk) disable iff (rst)
    (vertex_valid && !vertex_stall) |-> coef_status.ready)
    else $error("vertex transfer while coefficients are not built");

  // an angle write invalidates the matrix
  a_write_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (cfg_write_en && (cfg_index == REG_YAW || cfg_index == REG_PITCH ||
                      cfg_index == REG_ROLL)) |=> !coef_status.ready)
    else $error("coefficients still ready after an angle write");

  // the build never completes in the cycle of an angle write
  a_ready_rise_clean: assert property (@(posedge clk) disable iff (rst)
    $rose(coef_status.ready) |->
      !$past(cfg_write_en && (cfg_index == REG_YAW || cfg_index == REG_PITCH ||
                              cfg_index == REG_ROLL)))
    else $error("coefficient build finished across an angle write");

endmodule
